// ----- rtl/core/ibac_pkg.sv -----
// Shared constants, types and helpers of the border autocrop block.
package ibac_pkg;

  localparam int unsigned MAX_COLS_DEF   = 256;
  localparam int unsigned MAX_ROWS_DEF   = 256;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned SIZE_LIM   = (2 ** SIZE_W) - 1;
  localparam int unsigned PIX_FIELD_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned WIN_W      = 4 * SIZE_W;
  localparam int unsigned OUT_DATA_W = ((WIN_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT_EN   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CROP_RIGHT_EN  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP_EN    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_CROP_BOTTOM_EN = CFG_IDX_W'(5);

  typedef struct packed {
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
    logic              left_en;
    logic              right_en;
    logic              top_en;
    logic              bottom_en;
  } ibac_cfg_t;

  // first member in the highest bits, so win_left lands lowest
  typedef struct packed {
    logic [SIZE_W-1:0] height;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] top;
    logic [SIZE_W-1:0] left;
  } ibac_win_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SETUP,
    SC_RUN,
    SC_DONE
  } ibac_state_e;

  typedef enum logic [1:0] {
    PASS_TOP,
    PASS_LEFT,
    PASS_RIGHT,
    PASS_BOTTOM
  } ibac_pass_e;

  // zero counts as one, anything above the cap counts as the cap
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] cap);
    logic [SIZE_W-1:0] s;
    s = v;
    if (s == '0) begin
      s = SIZE_W'(1);
    end
    if (s > cap) begin
      s = cap;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/image_border_autocrop.sv -----
// Uniform-border autocrop: frame store load, edge scan and window result.
//
// Pixels enter on the s_axis channel in raster order, one word per cycle,
// into an on-chip frame store. The image size and the four side enables
// come from the cfg write port (index 0 cols, 1 rows, 2..5 left, right,
// top, bottom enable); the image ends when the pixel count reaches
// cols * rows as configured at that moment.
// After the last pixel, s_axis_tready_o drops and the scan sequencer
// compares lines of the store, two pixels per cycle through one address
// and compare unit. A line compare stops at the first mismatch or at the end
// of the line; each enabled side adds up to one compare per candidate line
// plus a setup step in the SC_SETUP state.
// The crop window is then held in an output register on m_axis until
// taken; loading of the next image may run meanwhile, but a finished
// scan waits for a free output register before it releases the input.
// Reset restores size 256 x 256 (clamped to the maximum), all sides
// enabled, and an empty pixel count; the store itself is not cleared.
module image_border_autocrop import ibac_pkg::*; #(
  parameter int unsigned MAX_COLS   = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PIX_FIELD_W-1:0] s_axis_tdata_i,   // [15:0] pixel_value
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [8:0] win_left, [17:9] win_top, [26:18] win_width, [35:27] win_height,
  // [39:36] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SIZE_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned TW    = $clog2(DEPTH + 1);
  localparam int unsigned SW    = (PIXEL_BITS < PIX_FIELD_W) ? PIXEL_BITS : PIX_FIELD_W;

  localparam logic [SIZE_W-1:0] COLS_CAP =
    SIZE_W'((MAX_COLS > SIZE_LIM) ? SIZE_LIM : MAX_COLS);
  localparam logic [SIZE_W-1:0] ROWS_CAP =
    SIZE_W'((MAX_ROWS > SIZE_LIM) ? SIZE_LIM : MAX_ROWS);

  ibac_cfg_t cfg_q, cfg_d;

  logic [TW-1:0]         count_q, count_d;
  logic                  out_vld_q, out_vld_d;
  ibac_win_t             out_win_q, out_win_d;
  logic [2*SIZE_W-1:0]   prod;
  logic [TW-1:0]         total;
  logic                  in_acc;
  logic                  last_px;
  logic                  scan_start;
  logic                  scan_busy;
  logic                  scan_done;
  logic                  scan_ack;
  ibac_win_t             scan_win;
  logic [AW-1:0]         raddr_a;
  logic [AW-1:0]         raddr_b;
  logic [SW-1:0]         rdata_a;
  logic [SW-1:0]         rdata_b;

  assign prod  = cfg_q.cols * cfg_q.rows;
  assign total = TW'(prod);

  assign s_axis_tready_o = !scan_busy;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign last_px         = ((TW + 1)'(count_q) + (TW + 1)'(1)) >= (TW + 1)'(total);
  assign scan_start      = in_acc && last_px;
  assign scan_ack        = scan_done && (!out_vld_q || m_axis_tready_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_COLS:     cfg_d.cols      = clamp_size(cfg_data_i, COLS_CAP);
        REG_IMAGE_ROWS:     cfg_d.rows      = clamp_size(cfg_data_i, ROWS_CAP);
        REG_CROP_LEFT_EN:   cfg_d.left_en   = cfg_data_i[0];
        REG_CROP_RIGHT_EN:  cfg_d.right_en  = cfg_data_i[0];
        REG_CROP_TOP_EN:    cfg_d.top_en    = cfg_data_i[0];
        REG_CROP_BOTTOM_EN: cfg_d.bottom_en = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (in_acc) begin
      count_d = last_px ? '0 : (count_q + TW'(1));
    end
  end

  // hold the window until taken
  always_comb begin
    out_vld_d = out_vld_q;
    out_win_d = out_win_q;
    if (scan_ack) begin
      out_vld_d = 1'b1;
      out_win_d = scan_win;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols      <= clamp_size(SIZE_RST, COLS_CAP);
      cfg_q.rows      <= clamp_size(SIZE_RST, ROWS_CAP);
      cfg_q.left_en   <= 1'b1;
      cfg_q.right_en  <= 1'b1;
      cfg_q.top_en    <= 1'b1;
      cfg_q.bottom_en <= 1'b1;
      count_q         <= '0;
      out_vld_q       <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_win_q <= out_win_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_win_q);

  ibac_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SW)
  ) u_frame_mem (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .waddr_i   (count_q[AW-1:0]),
    .wdata_i   (s_axis_tdata_i[SW-1:0]),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  ibac_scan_ctrl #(
    .AW (AW),
    .TW (TW),
    .SW (SW)
  ) u_scan_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .cfg_i     (cfg_q),
    .total_i   (total),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .busy_o    (scan_busy),
    .done_o    (scan_done),
    .win_o     (scan_win),
    .ack_i     (scan_ack)
  );

`ifndef NO_ASSERTIONS
  a_no_load_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_busy |-> !in_acc)
    else $error("pixel word accepted while the edge scan runs");

  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(scan_done))
    else $error("window word appeared without a finished scan");

  a_scan_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_ack |=> !scan_busy && m_axis_tvalid_o)
    else $error("scan not released after handing over its window");
`endif

endmodule

// ----- rtl/core/ibac_frame_mem.sv -----
// Frame store: one write port, two registered read ports.
module ibac_frame_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_a_q;
  logic [DW-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

// ----- rtl/core/ibac_scan_ctrl.sv -----
// Edge scan sequencer: compares store lines through one address/compare unit.
module ibac_scan_ctrl import ibac_pkg::*; #(
  parameter int unsigned AW = 16,
  parameter int unsigned TW = 17,
  parameter int unsigned SW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ibac_cfg_t     cfg_i,
  input  logic [TW-1:0] total_i,
  output logic [AW-1:0] raddr_a_o,
  output logic [AW-1:0] raddr_b_o,
  input  logic [SW-1:0] rdata_a_i,
  input  logic [SW-1:0] rdata_b_i,
  output logic          busy_o,
  output logic          done_o,
  output ibac_win_t     win_o,
  input  logic          ack_i
);

  ibac_state_e state_q, state_d;
  ibac_pass_e  pass_q, pass_d;
  logic        vld_q, vld_d;
  logic        last_q, last_d;

  logic [AW-1:0]     base_a_q, base_a_d;
  logic [AW-1:0]     base_b_q, base_b_d;
  logic [AW-1:0]     off_q, off_d;
  logic [SIZE_W-1:0] bidx_q, bidx_d;
  logic [SIZE_W-1:0] lim_q, lim_d;
  logic [SIZE_W-1:0] b0_q, b0_d;
  logic              down_q, down_d;
  logic [SIZE_W-1:0] j_q, j_d;
  logic [SIZE_W-1:0] edge_t_q, edge_t_d;
  logic [SIZE_W-1:0] edge_l_q, edge_l_d;
  logic [SIZE_W-1:0] edge_r_q, edge_r_d;
  logic [SIZE_W-1:0] edge_b_q, edge_b_d;

  logic              row_pass;
  logic [AW-1:0]     cols_a;
  logic [AW-1:0]     unit_step;
  logic [AW-1:0]     line_step;
  logic [SIZE_W-1:0] n_elem;
  logic              pix_eq;
  logic              line_end;
  logic              line_same;
  logic              issue;
  logic [AW-1:0]     bottom_base;

  assign row_pass    = (pass_q == PASS_TOP) || (pass_q == PASS_BOTTOM);
  assign cols_a      = AW'(cfg_i.cols);
  assign unit_step   = row_pass ? AW'(1) : cols_a;
  assign line_step   = row_pass ? cols_a : AW'(1);
  assign n_elem      = row_pass ? cfg_i.cols : cfg_i.rows;
  assign bottom_base = AW'(total_i - TW'(cfg_i.cols));

  // shared address unit
  assign raddr_a_o = off_q + base_a_q;
  assign raddr_b_o = off_q + base_b_q;

  assign pix_eq    = (rdata_a_i == rdata_b_i);
  assign line_end  = vld_q && (!pix_eq || last_q);
  assign line_same = vld_q && pix_eq && last_q;
  assign issue     = (state_q == SC_RUN) && (j_q < n_elem) && !line_end;

  always_comb begin
    logic              en;
    logic [SIZE_W-1:0] b0;
    logic [SIZE_W-1:0] lim;
    logic              dn;
    logic [AW-1:0]     base;
    logic [SIZE_W-1:0] found;
    ibac_pass_e        pass_nx;

    state_d  = state_q;
    pass_d   = pass_q;
    base_a_d = base_a_q;
    base_b_d = base_b_q;
    off_d    = off_q;
    bidx_d   = bidx_q;
    lim_d    = lim_q;
    b0_d     = b0_q;
    down_d   = down_q;
    j_d      = j_q;
    edge_t_d = edge_t_q;
    edge_l_d = edge_l_q;
    edge_r_d = edge_r_q;
    edge_b_d = edge_b_q;
    vld_d    = issue;
    last_d   = (j_q == (n_elem - SIZE_W'(1)));

    en    = 1'b0;
    b0    = '0;
    lim   = '0;
    dn    = 1'b0;
    base  = '0;
    found = (bidx_q == lim_q) ? b0_q : bidx_q;

    case (pass_q)
      PASS_TOP:   pass_nx = PASS_LEFT;
      PASS_LEFT:  pass_nx = PASS_RIGHT;
      PASS_RIGHT: pass_nx = PASS_BOTTOM;
      default:    pass_nx = PASS_BOTTOM;
    endcase

    case (pass_q)
      PASS_TOP: begin
        en  = cfg_i.top_en;
        lim = cfg_i.rows - SIZE_W'(1);
      end
      PASS_LEFT: begin
        en  = cfg_i.left_en;
        lim = cfg_i.cols - SIZE_W'(1);
      end
      PASS_RIGHT: begin
        en   = cfg_i.right_en;
        b0   = cfg_i.cols - SIZE_W'(1);
        dn   = 1'b1;
        base = cols_a - AW'(1);
      end
      default: begin
        en   = cfg_i.bottom_en;
        b0   = cfg_i.rows - SIZE_W'(1);
        dn   = 1'b1;
        base = bottom_base;
      end
    endcase

    case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          pass_d   = PASS_TOP;
          edge_t_d = '0;
          edge_l_d = '0;
          edge_r_d = cfg_i.cols - SIZE_W'(1);
          edge_b_d = cfg_i.rows - SIZE_W'(1);
          state_d  = SC_SETUP;
        end
      end
      SC_SETUP: begin
        if (en) begin
          base_a_d = base;
          base_b_d = base;
          bidx_d   = b0;
          b0_d     = b0;
          lim_d    = lim;
          down_d   = dn;
          off_d    = '0;
          j_d      = '0;
          state_d  = SC_RUN;
        end else if (pass_q == PASS_BOTTOM) begin
          state_d = SC_DONE;
        end else begin
          pass_d = pass_nx;
        end
      end
      SC_RUN: begin
        if (issue) begin
          off_d = off_q + unit_step;
          j_d   = j_q + SIZE_W'(1);
        end
        if (line_end) begin
          if (line_same && (bidx_q != lim_q)) begin
            // line matches: advance to the next candidate line
            bidx_d   = down_q ? (bidx_q - SIZE_W'(1)) : (bidx_q + SIZE_W'(1));
            base_b_d = down_q ? (base_b_q - line_step) : (base_b_q + line_step);
            off_d    = '0;
            j_d      = '0;
          end else begin
            case (pass_q)
              PASS_TOP:   edge_t_d = found;
              PASS_LEFT:  edge_l_d = found;
              PASS_RIGHT: edge_r_d = found;
              default:    edge_b_d = found;
            endcase
            if (pass_q == PASS_BOTTOM) begin
              state_d = SC_DONE;
            end else begin
              pass_d  = pass_nx;
              state_d = SC_SETUP;
            end
          end
        end
      end
      SC_DONE: begin
        if (ack_i) begin
          state_d = SC_IDLE;
        end
      end
      default: begin
        state_d = SC_IDLE;
      end
    endcase
  end

  // window from the edges found; an inverted axis falls back to full range
  always_comb begin
    logic [SIZE_W-1:0] t;
    logic [SIZE_W-1:0] b;
    logic [SIZE_W-1:0] l;
    logic [SIZE_W-1:0] r;
    t = edge_t_q;
    b = edge_b_q;
    l = edge_l_q;
    r = edge_r_q;
    if (b < t) begin
      t = '0;
      b = cfg_i.rows - SIZE_W'(1);
    end
    if (r < l) begin
      l = '0;
      r = cfg_i.cols - SIZE_W'(1);
    end
    win_o.left   = l + SIZE_W'(1);
    win_o.top    = t + SIZE_W'(1);
    win_o.width  = r - l + SIZE_W'(1);
    win_o.height = b - t + SIZE_W'(1);
  end

  assign busy_o = (state_q != SC_IDLE);
  assign done_o = (state_q == SC_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      pass_q  <= PASS_TOP;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    base_a_q <= base_a_d;
    base_b_q <= base_b_d;
    off_q    <= off_d;
    bidx_q   <= bidx_d;
    lim_q    <= lim_d;
    b0_q     <= b0_d;
    down_q   <= down_d;
    j_q      <= j_d;
    edge_t_q <= edge_t_d;
    edge_l_q <= edge_l_d;
    edge_r_q <= edge_r_d;
    edge_b_q <= edge_b_d;
  end

endmodule

// ----- tb/sv/image_border_autocrop_tb.sv -----
// Self-checking border autocrop testbench: directed, stalled back-to-back, random images.
module image_border_autocrop_tb import ibac_pkg::*; ();

  localparam int unsigned STORE_WORDS = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam int          WDOG_LIMIT  = 20000;
  localparam int          HOLD_CYCLES = 600;
  localparam int          RAND_PIXELS = 550;
  localparam int          RAND_IMAGES = 16;
  localparam int          MAX_SHOWN   = 10;
  localparam int          DIR_ROWS    = 16;

  // indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_BEAT
  } rx_mode_e;

  // box [r0..r1] x [c0..c1] of fg (or noise) on bg, plus one odd pixel at (sr, sc)
  typedef struct packed {
    int                     r0;
    int                     r1;
    int                     c0;
    int                     c1;
    int                     sr;
    int                     sc;
    logic [PIX_FIELD_W-1:0] bg;
    logic [PIX_FIELD_W-1:0] fg;
    bit                     noise;
  } img_t;

  // -1 keeps a register; wr_en is {bottom, top, right, left}
  typedef struct packed {
    int   wr_cols;
    int   wr_rows;
    int   wr_en;
    bit   wr_spare;
    img_t img;
    bit   typed;
    int   x_left;
    int   x_top;
    int   x_width;
    int   x_height;
  } dir_row_t;

  logic                   clk      = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [PIX_FIELD_W-1:0] s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
  logic [SIZE_W-1:0]      cfg_data = '0;

  // predictor copy of configuration and frame
  int                     cols_m   = 256;
  int                     rows_m   = 256;
  bit                     left_m   = 1'b1;
  bit                     right_m  = 1'b1;
  bit                     top_m    = 1'b1;
  bit                     bottom_m = 1'b1;
  logic [PIX_FIELD_W-1:0] frame_mem [STORE_WORDS];
  int                     load_cnt = 0;
  ibac_win_t              win_q [$];
  bit                     hand_valid = 1'b0;
  ibac_win_t              hand_win;

  int        err_cnt    = 0;
  int        pix_cnt    = 0;
  int        img_cnt    = 0;
  int        wr_cnt     = 0;
  int        burst_left = 0;
  int        gap_max    = 0;
  int        hold_req   = 0;
  int        hold_ack   = 0;
  int        hold_left  = 0;
  int        rx_cnt     = 0;
  rx_mode_e  rx_mode    = RX_ALWAYS;
  int        stall_cyc  = 0;
  dir_row_t  dir_tab [DIR_ROWS];

  image_border_autocrop i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int size_of(int raw);
    int s;
    s = raw & SIZE_LIM;
    if (s == 0) s = 1;
    if (s > 256) s = 256;
    return s;
  endfunction

  function automatic bit rows_match(int a, int b);
    for (int c = 0; c < cols_m; c++) begin
      if (frame_mem[a * cols_m + c] != frame_mem[b * cols_m + c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit cols_match(int a, int b);
    for (int r = 0; r < rows_m; r++) begin
      if (frame_mem[r * cols_m + a] != frame_mem[r * cols_m + b]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // scan the stored image the way the block does and build its window
  function automatic ibac_win_t find_window();
    int        t;
    int        l;
    int        rr;
    int        b;
    ibac_win_t w;
    t  = 0;
    l  = 0;
    rr = cols_m - 1;
    b  = rows_m - 1;
    if (top_m) begin
      while (t < rows_m - 1 && rows_match(0, t)) t++;
      if (t >= rows_m - 1) t = 0;
    end
    if (left_m) begin
      while (l < cols_m - 1 && cols_match(0, l)) l++;
      if (l >= cols_m - 1) l = 0;
    end
    if (right_m) begin
      while (rr > 0 && cols_match(cols_m - 1, rr)) rr--;
      if (rr == 0) rr = cols_m - 1;
    end
    if (bottom_m) begin
      while (b > 0 && rows_match(rows_m - 1, b)) b--;
      if (b == 0) b = rows_m - 1;
    end
    // an inverted axis falls back to the full range
    if (b < t) begin
      t = 0;
      b = rows_m - 1;
    end
    if (rr < l) begin
      l  = 0;
      rr = cols_m - 1;
    end
    w.left   = SIZE_W'(l + 1);
    w.top    = SIZE_W'(t + 1);
    w.width  = SIZE_W'(rr - l + 1);
    w.height = SIZE_W'(b - t + 1);
    return w;
  endfunction

  function automatic void take_pixel(logic [PIX_FIELD_W-1:0] v);
    ibac_win_t w;
    frame_mem[load_cnt] = v;
    load_cnt++;
    pix_cnt++;
    if (load_cnt >= cols_m * rows_m) begin
      load_cnt = 0;
      w = find_window();
      if (hand_valid) begin
        w = hand_win;
        hand_valid = 1'b0;
      end
      win_q.push_back(w);
      img_cnt++;
    end
  endfunction

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= SIZE_W'(data);
    @(posedge clk);
    wr_cnt++;
  endtask

  // enable writes carry random upper bits; only bit 0 should count
  task automatic apply_cfg(input int cols_raw, input int rows_raw, input int en,
                           input bit spare);
    if (cols_raw >= 0) begin
      put_reg(REG_IMAGE_COLS, cols_raw);
      cols_m = size_of(cols_raw);
    end
    if (rows_raw >= 0) begin
      put_reg(REG_IMAGE_ROWS, rows_raw);
      rows_m = size_of(rows_raw);
    end
    if (en >= 0) begin
      put_reg(REG_CROP_LEFT_EN,   ($urandom_range(0, 255) << 1) | en[0]);
      put_reg(REG_CROP_RIGHT_EN,  ($urandom_range(0, 255) << 1) | en[1]);
      put_reg(REG_CROP_TOP_EN,    ($urandom_range(0, 255) << 1) | en[2]);
      put_reg(REG_CROP_BOTTOM_EN, ($urandom_range(0, 255) << 1) | en[3]);
      left_m   = en[0];
      right_m  = en[1];
      top_m    = en[2];
      bottom_m = en[3];
    end
    if (spare) begin
      put_reg(REG_SPARE_A, $urandom_range(0, SIZE_LIM));
      put_reg(REG_SPARE_B, $urandom_range(0, SIZE_LIM));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(input logic [PIX_FIELD_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    take_pixel(v);
  endtask

  task automatic send_image(input img_t im);
    logic [PIX_FIELD_W-1:0] v;
    for (int r = 0; r < rows_m; r++) begin
      for (int c = 0; c < cols_m; c++) begin
        v = im.bg;
        if (r >= im.r0 && r <= im.r1 && c >= im.c0 && c <= im.c1)
          v = im.noise ? PIX_FIELD_W'($urandom) : im.fg;
        if (r == im.sr && c == im.sc) v = PIX_FIELD_W'($urandom);
        push_pixel(v);
      end
    end
  endtask

  // hold the input until every window is out, then let the scan logic settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (win_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // result side: check every window word, stall on a changing pattern
  always @(posedge clk) begin
    ibac_win_t got;
    ibac_win_t want;
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        got = ibac_win_t'(m_tdata[WIN_W-1:0]);
        if (win_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("unexpected window: left %0d top %0d width %0d height %0d",
                     got.left, got.top, got.width, got.height);
        end else begin
          want = win_q.pop_front();
          if (got.left !== want.left || got.top !== want.top ||
              got.width !== want.width || got.height !== want.height ||
              m_tdata[OUT_DATA_W-1:WIN_W] !== '0) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display({"window mismatch: expected left %0d top %0d width %0d height %0d,",
                        " got left %0d top %0d width %0d height %0d pad %h"},
                       want.left, want.top, want.width, want.height,
                       got.left, got.top, got.width, got.height,
                       m_tdata[OUT_DATA_W-1:WIN_W]);
          end
        end
      end
      rx_cnt <= rx_cnt + 1;
      if (rx_cnt % 97 == 96) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= (rx_cnt % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cyc <= 0;
    end else if (stall_cyc == WDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d windows pending",
               WDOG_LIMIT, win_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
  end

  initial begin
    img_t im;
    int   k;
    int   n_img;
    int   big;
    int   cols_raw;
    int   rows_raw;
    int   en;
    int   pix_base;
    int   img_base;

    dir_tab = '{
      // reset size 256 columns kept, one row, reset enables kept
      '{ -1,   1, -1, 0, '{0,   0,  10, 200, -1, -1, 16'h0000, 16'hFFFF, 0}, 1,
         11, 1, 191, 1},
      '{  1,   1, 15, 0, '{0,   0,   0,   0, -1, -1, 16'h0000, 16'hFFFF, 0}, 1,
          1, 1, 1, 1},
      // size zero counts as one, oversize counts as the maximum
      '{  0, 300, -1, 0, '{5, 250,   0,   0, -1, -1, 16'hFFFF, 16'h0000, 0}, 1,
          1, 6, 1, 246},
      '{  8,   6, 15, 0, '{1,   4,   2,   5, -1, -1, 16'h1234, 16'hABCD, 0}, 1,
          3, 2, 4, 4},
      // uniform image: every scan runs into the opposite edge
      '{  8,   6, -1, 0, '{1,   0,   0,   0, -1, -1, 16'h5555, 16'h0000, 0}, 1,
          1, 1, 8, 6},
      // inverted rows, then inverted columns
      '{  5,   4, -1, 0, '{2,   3,   0,   4, -1, -1, 16'h0000, 16'hFFFF, 0}, 1,
          1, 1, 5, 4},
      '{  4,   3, -1, 0, '{0,   2,   2,   3, -1, -1, 16'h00FF, 16'hFF00, 0}, 1,
          1, 1, 4, 3},
      // sides disabled
      '{  8,   6, 10, 0, '{1,   4,   2,   5, -1, -1, 16'h1234, 16'hABCD, 0}, 1,
          1, 1, 6, 5},
      '{ -1,  -1,  5, 0, '{1,   4,   2,   5, -1, -1, 16'h1234, 16'hABCD, 0}, 1,
          3, 2, 6, 5},
      // writes to unused indexes
      '{ -1,  -1, 15, 1, '{1,   4,   2,   5, -1, -1, 16'h1234, 16'hABCD, 0}, 1,
          3, 2, 4, 4},
      '{  8,   6, -1, 0, '{0,   2,   0,   3, -1, -1, 16'hAAAA, 16'h5555, 0}, 0,
          0, 0, 0, 0},
      '{  8,   8, -1, 0, '{0,  15,   0,  15, -1, -1, 16'h0000, 16'h0000, 1}, 0,
          0, 0, 0, 0},
      '{ -1,  -1, -1, 0, '{3,  12,   4,   9, -1, -1, 16'h8001, 16'h0000, 1}, 0,
          0, 0, 0, 0},
      '{  2,   2, -1, 0, '{0,   0,   0,   0, -1, -1, 16'h0000, 16'hFFFF, 0}, 0,
          0, 0, 0, 0},
      '{  7,   3, -1, 0, '{1,   1,   2,   4, -1, -1, 16'h0F0F, 16'hF0F0, 0}, 0,
          0, 0, 0, 0},
      '{511,   1, -1, 0, '{0,   0, 100, 100, -1, -1, 16'h0000, 16'h0001, 0}, 0,
          0, 0, 0, 0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_max = 3;
    foreach (dir_tab[i]) begin
      wait_drained();
      apply_cfg(dir_tab[i].wr_cols, dir_tab[i].wr_rows, dir_tab[i].wr_en,
                dir_tab[i].wr_spare);
      hand_valid = dir_tab[i].typed;
      hand_win.left   = SIZE_W'(dir_tab[i].x_left);
      hand_win.top    = SIZE_W'(dir_tab[i].x_top);
      hand_win.width  = SIZE_W'(dir_tab[i].x_width);
      hand_win.height = SIZE_W'(dir_tab[i].x_height);
      send_image(dir_tab[i].img);
    end

    // back-to-back images against a long output stall: the block must back up
    wait_drained();
    apply_cfg(3, 3, 15, 0);
    gap_max  = 0;
    hold_req <= hold_req + 1;
    repeat (6) send_image(img_t'{0, 2, 0, 2, -1, -1, 16'h0000, 16'h0000, 1});

    pix_base = pix_cnt;
    img_base = img_cnt;
    while (pix_cnt - pix_base < RAND_PIXELS || img_cnt - img_base < RAND_IMAGES) begin
      wait_drained();
      big = ($urandom_range(0, 24) == 0);
      if (big) begin
        cols_raw = ($urandom_range(0, 1) == 1) ? 256 : $urandom_range(100, SIZE_LIM);
        rows_raw = $urandom_range(1, 2);
        if ($urandom_range(0, 1) == 1) begin
          k        = cols_raw;
          cols_raw = rows_raw;
          rows_raw = k;
        end
      end else begin
        cols_raw = $urandom_range(0, 10);
        rows_raw = $urandom_range(0, 10);
      end
      en = ($urandom_range(0, 1) == 1) ? 15 : $urandom_range(0, 15);
      apply_cfg(cols_raw, rows_raw, en, $urandom_range(0, 7) == 0);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      n_img   = big ? 1 : $urandom_range(1, 3);
      repeat (n_img) begin
        // kind: 0..4 plain box, 5..6 noisy box, 7 all noise, 8..9 flat, mostly with a speck
        k     = $urandom_range(0, 9);
        im.r0 = $urandom_range(0, rows_m - 1);
        im.r1 = $urandom_range(im.r0, rows_m - 1);
        im.c0 = $urandom_range(0, cols_m - 1);
        im.c1 = $urandom_range(im.c0, cols_m - 1);
        im.sr = -1;
        im.sc = -1;
        im.bg = ($urandom_range(0, 7) == 0) ? '0 : PIX_FIELD_W'($urandom);
        im.fg = ($urandom_range(0, 7) == 0) ? '1 : PIX_FIELD_W'($urandom);
        im.noise = (k == 5 || k == 6);
        if (k == 7) begin
          im.r0    = 0;
          im.r1    = rows_m - 1;
          im.c0    = 0;
          im.c1    = cols_m - 1;
          im.noise = 1'b1;
        end else if (k >= 8) begin
          im.r0 = 1;
          im.r1 = 0;
          if ($urandom_range(0, 3) != 0) begin
            im.sr = $urandom_range(0, rows_m - 1);
            im.sc = $urandom_range(0, cols_m - 1);
          end
        end
        send_image(im);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);

    $display("Ran %0d images from %0d pixels with %0d register writes (%0d errors).",
             img_cnt, pix_cnt, wr_cnt, err_cnt);
    $display("Sizes 1x1 up to 256 on either axis, all side enables, a long output stall.");
    if (err_cnt == 0 && win_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
